[rtl/sha256bs_pkg.sv]
// Shared types, round constants and initial hash values for the SHA-256 byte-stream hasher.
package sha256bs_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] vars_t;     // working variables, index 0 is a
    typedef logic [15:0][31:0] sched_t;   // 16-word schedule window / block buffer

    localparam int unsigned ROUNDS = 64;
    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned LEN_BYTE_POS = 56;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam vars_t INIT_H = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

endpackage

[rtl/sha256bs_if.sv]
// Valid/ready channel interfaces for message input and digest output.
interface sha256bs_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface sha256bs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

[rtl/sha256bs_round.sv]
// One SHA-256 compression round together with one message schedule step.
module sha256bs_round
(
    input  sha256bs_pkg::vars_t  vars,
    input  sha256bs_pkg::sched_t sched,
    input  sha256bs_pkg::word_t  k,
    output sha256bs_pkg::vars_t  vars_out,
    output sha256bs_pkg::sched_t sched_out
);

    function automatic sha256bs_pkg::word_t rotr(sha256bs_pkg::word_t x, int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    sha256bs_pkg::word_t big0;
    sha256bs_pkg::word_t big1;
    sha256bs_pkg::word_t ch;
    sha256bs_pkg::word_t maj;
    sha256bs_pkg::word_t t1;
    sha256bs_pkg::word_t t2;
    sha256bs_pkg::word_t s0;
    sha256bs_pkg::word_t s1;
    sha256bs_pkg::word_t w_new;

    always_comb
    begin
        big1 = rotr(vars[4], 6) ^ rotr(vars[4], 11) ^ rotr(vars[4], 25);
        ch   = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
        t1   = vars[7] + big1 + ch + k + sched[0];
        big0 = rotr(vars[0], 2) ^ rotr(vars[0], 13) ^ rotr(vars[0], 22);
        maj  = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
        t2   = big0 + maj;

        vars_out[7] = vars[6];
        vars_out[6] = vars[5];
        vars_out[5] = vars[4];
        vars_out[4] = vars[3] + t1;
        vars_out[3] = vars[2];
        vars_out[2] = vars[1];
        vars_out[1] = vars[0];
        vars_out[0] = t1 + t2;

        s0    = rotr(sched[1], 7) ^ rotr(sched[1], 18) ^ (sched[1] >> 3);
        s1    = rotr(sched[14], 17) ^ rotr(sched[14], 19) ^ (sched[14] >> 10);
        w_new = s1 + sched[9] + s0 + sched[0];

        sched_out = {w_new, sched[15:1]};
    end

endmodule

[rtl/sha256_byte_stream_hasher.sv]
// Top level of the SHA-256 byte-stream hasher with block buffer, sequencer and digest output.
//
// Usage:
//   msg is a valid/ready sink. A transaction with kind 0 appends data_byte to
//   the message; kind 1 ends the message. digest is a valid/ready source that
//   delivers the eight digest words, word_index 0 (most significant) first,
//   last_word set on index 7.
// Timing:
//   The 64th byte of a block starts the compression: 64 rounds through the one
//   round unit, one per cycle, then a fold into the hash. msg.ready is low
//   throughout, so no new byte is taken until the block has been folded in.
//   An end transaction pads the block, then compresses one final block (fewer
//   than 56 bytes pending) or two final blocks, then delivers the digest words
//   at one per cycle while digest.ready is high.
// Stalls and reset:
//   msg.ready stays low from the end transaction until the last digest word
//   has been taken; a stalled receiver simply holds the current word.
//   Reset (rst_n low) returns to the initial hash with an empty message.
module sha256_byte_stream_hasher
(
    input logic clk,
    input logic rst_n,
    sha256bs_in_if.sink    msg,
    sha256bs_out_if.source digest
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_COMP = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [5:0]           count_reg, count_next;
    logic [63:0]          bitlen_reg, bitlen_next;
    sha256bs_pkg::vars_t  hash_reg, hash_next;
    logic                 pad2_reg, pad2_next;
    logic                 final_reg, final_next;
    logic [5:0]           round_reg, round_next;
    logic [2:0]           idx_reg, idx_next;
    sha256bs_pkg::vars_t  vars_reg, vars_next;
    sha256bs_pkg::sched_t sched_reg, sched_next;

    sha256bs_pkg::vars_t  vars_rnd;
    sha256bs_pkg::sched_t sched_rnd;
    logic                 msg_take;
    logic                 dig_take;
    logic [4:0]           lane_off;

    sha256bs_round u_round
    (
        .vars      (vars_reg),
        .sched     (sched_reg),
        .k         (sha256bs_pkg::ROUND_K[round_reg]),
        .vars_out  (vars_rnd),
        .sched_out (sched_rnd)
    );

    assign msg.ready          = (state_reg == S_IDLE);
    assign msg_take           = msg.valid && msg.ready;
    assign digest.valid       = (state_reg == S_OUT);
    assign digest.digest_word = hash_reg[idx_reg];
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = (idx_reg == 3'd7);
    assign dig_take           = digest.valid && digest.ready;
    assign lane_off           = {~count_reg[1:0], 3'b000};

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        bitlen_next = bitlen_reg;
        hash_next   = hash_reg;
        pad2_next   = pad2_reg;
        final_next  = final_reg;
        round_next  = round_reg;
        idx_next    = idx_reg;
        vars_next   = vars_reg;
        sched_next  = sched_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (msg_take)
                begin
                    if (!msg.kind)
                    begin
                        sched_next[count_reg[5:2]][lane_off +: 8] = msg.data_byte;
                        bitlen_next = bitlen_reg + 64'd8;
                        count_next  = count_reg + 6'd1;
                        if (count_reg == 6'(sha256bs_pkg::BLOCK_BYTES - 1))
                        begin
                            state_next = S_COMP;
                            final_next = 1'b0;
                            pad2_next  = 1'b0;
                            round_next = '0;
                            vars_next  = hash_reg;
                        end
                    end
                    else
                    begin
                        // keep bytes before the count, pad byte at it, zeros after
                        for (int p = 0; p < sha256bs_pkg::BLOCK_BYTES; p++)
                        begin
                            if (6'(p) == count_reg)
                                sched_next[p / 4][(3 - p % 4) * 8 +: 8] =
                                    sha256bs_pkg::PAD_BYTE;
                            else if (6'(p) > count_reg)
                                sched_next[p / 4][(3 - p % 4) * 8 +: 8] = 8'h00;
                        end
                        if (count_reg < 6'(sha256bs_pkg::LEN_BYTE_POS))
                        begin
                            sched_next[14] = bitlen_reg[63:32];
                            sched_next[15] = bitlen_reg[31:0];
                            pad2_next      = 1'b0;
                        end
                        else
                        begin
                            pad2_next = 1'b1;
                        end
                        state_next = S_COMP;
                        final_next = 1'b1;
                        round_next = '0;
                        vars_next  = hash_reg;
                    end
                end
            end
            S_COMP:
            begin
                vars_next  = vars_rnd;
                sched_next = sched_rnd;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'(sha256bs_pkg::ROUNDS - 1))
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                for (int i = 0; i < 8; i++)
                    hash_next[i] = hash_reg[i] + vars_reg[i];
                count_next = '0;
                if (pad2_reg)
                begin
                    sched_next     = '0;
                    sched_next[14] = bitlen_reg[63:32];
                    sched_next[15] = bitlen_reg[31:0];
                    pad2_next      = 1'b0;
                    vars_next      = hash_next;
                    round_next     = '0;
                    state_next     = S_COMP;
                end
                else if (final_reg)
                begin
                    idx_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (dig_take)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        hash_next   = sha256bs_pkg::INIT_H;
                        bitlen_next = '0;
                        count_next  = '0;
                        final_next  = 1'b0;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            bitlen_reg <= '0;
            hash_reg   <= sha256bs_pkg::INIT_H;
            pad2_reg   <= 1'b0;
            final_reg  <= 1'b0;
            round_reg  <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            bitlen_reg <= bitlen_next;
            hash_reg   <= hash_next;
            pad2_reg   <= pad2_next;
            final_reg  <= final_next;
            round_reg  <= round_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vars_reg  <= vars_next;
        sched_reg <= sched_next;
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        digest.valid |-> !msg.ready)
        else $error("input accepted while digest pending");

    a_last_reinit: assert property (@(posedge clk) disable iff (!rst_n)
        (dig_take && digest.last_word) |=> (msg.ready && bitlen_reg == 64'd0
                                            && count_reg == 6'd0))
        else $error("state not reinitialised after digest");

    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMP && round_reg == 6'(sha256bs_pkg::ROUNDS - 1))
            |=> state_reg == S_FIN)
        else $error("compression did not finish after last round");

    a_byte_enters_comp: assert property (@(posedge clk) disable iff (!rst_n)
        (msg_take && !msg.kind && count_reg == 6'd63) |=> (state_reg == S_COMP
                                                           && round_reg == 6'd0))
        else $error("full block did not start compression");

endmodule
